// ----- src/lzo_pkg.sv -----
// Shared types, constants and request/result codes of the layer z-order controller.
package lzo_pkg;

    localparam int MAX_LAYERS = 32;
    localparam int LID_W      = $clog2(MAX_LAYERS);
    localparam int HT_W       = LID_W + 2;

    // Request types
    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_SIZE    = 3'd1;
    localparam logic [2:0] REQ_HEIGHT  = 3'd2;
    localparam logic [2:0] REQ_MOVE    = 3'd3;
    localparam logic [2:0] REQ_REFRESH = 3'd4;
    localparam logic [2:0] REQ_FREE    = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_REBUILD = 2'd1;
    localparam logic [1:0] KIND_REDRAW  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_HIDDEN  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Datapath operations requested by the controller
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_ALLOC     = 4'd2;
    localparam logic [3:0] OP_SIZE      = 4'd3;
    localparam logic [3:0] OP_MOVE      = 4'd4;
    localparam logic [3:0] OP_SHIFT_DN  = 4'd5;
    localparam logic [3:0] OP_SHIFT_UP  = 4'd6;
    localparam logic [3:0] OP_PLACE     = 4'd7;
    localparam logic [3:0] OP_EMIT      = 4'd8;
    localparam logic [3:0] OP_FREE      = 4'd9;
    localparam logic [3:0] OP_SETH      = 4'd10;

    // Controller to datapath command
    typedef struct packed {
        logic [3:0]       op;
        logic [1:0]       kind;
        logic [1:0]       rect_sel;     // 0 stored rect, 1 new position rect, 2 refresh rect
        logic [1:0]       hsel;         // which height pair to use
        logic [1:0]       status;
        logic             last;
    } lzo_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic             req_bad;
        logic             free_found;
        logic             hidden;
        logic signed [HT_W-1:0] old_h;
        logic signed [HT_W-1:0] new_h;
        logic signed [HT_W-1:0] k;
        logic signed [HT_W-1:0] top;
        logic             out_busy;
    } lzo_stat_t;

endpackage

// ----- src/lzo_datapath.sv -----
// Layer table, stack memory, region arithmetic and output register.
module lzo_datapath
    import lzo_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_index,
    input  logic [12:0]             cfg_data,
    input  logic                    in_take,
    input  logic [2:0]              req_type,
    input  logic [4:0]              layer_id,
    input  logic signed [14:0]      pos_x,
    input  logic signed [14:0]      pos_y,
    input  logic signed [14:0]      end_x,
    input  logic signed [14:0]      end_y,
    input  logic signed [15:0]      new_height,
    input  lzo_cmd_t                cmd,
    output lzo_stat_t               stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              kind,
    output logic [12:0]             rect_x0,
    output logic [12:0]             rect_y0,
    output logic [12:0]             rect_x1,
    output logic [12:0]             rect_y1,
    output logic signed [6:0]       height_from,
    output logic signed [6:0]       height_to,
    output logic [4:0]              result_layer,
    output logic [1:0]              status,
    output logic                    last
);

    // Screen size registers
    logic [12:0] scr_w_reg, scr_h_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= 13'd320;
            scr_h_reg <= 13'd200;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_WIDTH)
                scr_w_reg <= cfg_data;
            else
                scr_h_reg <= cfg_data;
        end
    end

    // Layer table and stack, small register files
    logic [LID_W-1:0]        stack_mem [MAX_LAYERS];
    logic signed [HT_W-1:0]  hgt_mem   [MAX_LAYERS];
    logic signed [14:0]      px_mem    [MAX_LAYERS];
    logic signed [14:0]      py_mem    [MAX_LAYERS];
    logic [12:0]             w_mem     [MAX_LAYERS];
    logic [12:0]             r_mem     [MAX_LAYERS];
    logic [MAX_LAYERS-1:0]   in_use_reg;
    logic signed [HT_W-1:0]  top_reg;

    // Captured request
    logic [2:0]              rq_reg;
    logic [LID_W-1:0]        id_reg;
    logic signed [14:0]      qx_reg, qy_reg, ex_reg, ey_reg;
    logic signed [15:0]      nh_reg;
    logic                    idbad_reg;

    // Working values of the current request
    logic signed [HT_W-1:0]  old_reg, h_reg, k_reg;
    logic signed [14:0]      ox_reg, oy_reg;
    logic [12:0]             lw_reg, lr_reg;
    logic [LID_W-1:0]        res_reg;
    logic                    found_reg;

    // Lowest free layer
    logic [LID_W-1:0] free_idx;
    logic             free_any;
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = MAX_LAYERS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_idx = LID_W'(i);
                free_any = 1'b1;
            end
        end
    end

    // Clamp of the requested height to -1..top+1
    logic signed [HT_W-1:0] clamp_h;
    logic signed [16:0]     topp1;
    always_comb
    begin
        topp1 = 17'(top_reg) + 17'sd1;
        if (17'(nh_reg) > topp1)
            clamp_h = HT_W'(topp1);
        else if (nh_reg < -16'sd1)
            clamp_h = -HT_W'(1);
        else
            clamp_h = HT_W'(nh_reg);
    end

    // Stack index for shifting
    logic [LID_W-1:0] k_idx, km1_idx, kp1_idx, h_idx;
    logic [LID_W-1:0] mv_dn, mv_up;
    assign k_idx   = k_reg[LID_W-1:0];
    assign km1_idx = LID_W'(k_reg - 1);
    assign kp1_idx = LID_W'(k_reg + 1);
    assign h_idx   = h_reg[LID_W-1:0];
    assign mv_dn   = stack_mem[km1_idx];
    assign mv_up   = stack_mem[kp1_idx];

    logic signed [14:0] satx, saty;
    assign satx = (ex_reg < 0) ? 15'sd0 : ((ex_reg > 15'sd4096) ? 15'sd4096 : ex_reg);
    assign saty = (ey_reg < 0) ? 15'sd0 : ((ey_reg > 15'sd4096) ? 15'sd4096 : ey_reg);

    // Table, stack and working register updates
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SIZE:
            begin
                w_mem[id_reg] <= satx[12:0];
                r_mem[id_reg] <= saty[12:0];
            end
            OP_MOVE:
            begin
                px_mem[id_reg] <= qx_reg;
                py_mem[id_reg] <= qy_reg;
            end
            OP_ALLOC:
                if (free_any)
                    hgt_mem[free_idx] <= -HT_W'(1);
            OP_SETH:
                hgt_mem[id_reg] <= h_reg;
            OP_SHIFT_DN:
            begin
                stack_mem[k_idx] <= mv_dn;
                hgt_mem[mv_dn]   <= k_reg;
            end
            OP_SHIFT_UP:
            begin
                stack_mem[k_idx] <= mv_up;
                hgt_mem[mv_up]   <= k_reg;
            end
            OP_PLACE:
                stack_mem[h_idx] <= id_reg;
            default:
            begin
            end
        endcase
    end

    // In-use flags and stack top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            top_reg    <= -HT_W'(1);
        end
        else
        begin
            if (cmd.op == OP_ALLOC && free_any)
                in_use_reg[free_idx] <= 1'b1;
            if (cmd.op == OP_FREE)
                in_use_reg[id_reg] <= 1'b0;
            if (cmd.op == OP_SETH)
            begin
                if (h_reg < 0 && old_reg >= 0)
                    top_reg <= HT_W'(top_reg - 1);
                else if (old_reg < 0 && h_reg >= 0)
                    top_reg <= HT_W'(top_reg + 1);
            end
        end
    end

    // Request capture and per-request working values
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rq_reg    <= req_type;
            id_reg    <= layer_id[LID_W-1:0];
            idbad_reg <= (32'(layer_id) >= MAX_LAYERS);
            qx_reg    <= pos_x;
            qy_reg    <= pos_y;
            ex_reg    <= end_x;
            ey_reg    <= end_y;
            nh_reg    <= new_height;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                old_reg   <= hgt_mem[id_reg];
                ox_reg    <= px_mem[id_reg];
                oy_reg    <= py_mem[id_reg];
                lw_reg    <= w_mem[id_reg];
                lr_reg    <= r_mem[id_reg];
                res_reg   <= id_reg;
                found_reg <= free_any;
                // Moves and refreshes report at the layer's own height
                if (rq_reg == REQ_FREE)
                    h_reg <= -HT_W'(1);
                else if (rq_reg == REQ_HEIGHT)
                    h_reg <= clamp_h;
                else
                    h_reg <= hgt_mem[id_reg];
                if (rq_reg == REQ_ALLOC)
                    res_reg <= free_any ? free_idx : '0;
            end
            OP_SETH:
                k_reg <= (old_reg < 0) ? HT_W'(top_reg + 1) : old_reg;
            OP_SHIFT_DN:
                k_reg <= HT_W'(k_reg - 1);
            OP_SHIFT_UP:
                k_reg <= HT_W'(k_reg + 1);
            default:
            begin
            end
        endcase
    end

    // Status for the controller
    assign stat.req_bad    = idbad_reg || !in_use_reg[id_reg] || rq_reg > REQ_FREE;
    assign stat.free_found = found_reg;
    assign stat.hidden     = old_reg < 0;
    assign stat.old_h      = old_reg;
    assign stat.new_h      = h_reg;
    assign stat.k          = k_reg;
    assign stat.top        = top_reg;
    assign stat.out_busy   = out_valid && !out_ready;

    // Region selection and clipping
    logic signed [15:0] ax0, ay0, ax1, ay1;
    logic signed [HT_W-1:0] hf, ht;
    always_comb
    begin
        case (cmd.rect_sel)
            2'd1:
            begin
                ax0 = 16'(qx_reg);
                ay0 = 16'(qy_reg);
                ax1 = 16'(qx_reg) + 16'($signed({1'b0, lw_reg}));
                ay1 = 16'(qy_reg) + 16'($signed({1'b0, lr_reg}));
            end
            2'd2:
            begin
                ax0 = 16'(ox_reg) + 16'(qx_reg);
                ay0 = 16'(oy_reg) + 16'(qy_reg);
                ax1 = 16'(ox_reg) + 16'(ex_reg);
                ay1 = 16'(oy_reg) + 16'(ey_reg);
            end
            default:
            begin
                ax0 = 16'(ox_reg);
                ay0 = 16'(oy_reg);
                ax1 = 16'(ox_reg) + 16'($signed({1'b0, lw_reg}));
                ay1 = 16'(oy_reg) + 16'($signed({1'b0, lr_reg}));
            end
        endcase
        case (cmd.hsel)
            2'd1:
            begin
                hf = HT_W'(h_reg + 1);
                ht = old_reg;
            end
            2'd2:
            begin
                hf = h_reg;
                ht = h_reg;
            end
            2'd3:
            begin
                hf = '0;
                ht = HT_W'(old_reg - 1);
            end
            default:
            begin
                hf = '0;
                ht = '0;
            end
        endcase
    end

    function automatic logic [12:0] clip(input logic signed [15:0] v, input logic [12:0] lim);
        if (v < 0)
            return 13'd0;
        else if (v > $signed({3'b0, lim}))
            return lim;
        else
            return v[12:0];
    endfunction

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.op == OP_EMIT)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            kind         <= cmd.kind;
            result_layer <= res_reg;
            status       <= cmd.status;
            last         <= cmd.last;
            if (cmd.kind == KIND_ACK)
            begin
                rect_x0     <= '0;
                rect_y0     <= '0;
                rect_x1     <= '0;
                rect_y1     <= '0;
                height_from <= '0;
                height_to   <= '0;
            end
            else
            begin
                rect_x0     <= clip(ax0, scr_w_reg);
                rect_y0     <= clip(ay0, scr_h_reg);
                rect_x1     <= clip(ax1, scr_w_reg);
                rect_y1     <= clip(ay1, scr_h_reg);
                // The rebuild command runs up to the current top
                height_from <= 7'(hf);
                height_to   <= (cmd.kind == KIND_REBUILD) ? 7'(top_reg) : 7'(ht);
            end
        end
    end

    // A stored result is never overwritten while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> !(out_valid && !out_ready))
        else $error("result overwritten while stalled");
    // The stack top stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        top_reg >= -HT_W'(1) && top_reg < HT_W'(MAX_LAYERS))
        else $error("stack top out of range");
    // The stack top changes only on a height update, by at most one per request
    assert property (@(posedge clk) disable iff (!rst_n)
        top_reg != $past(top_reg) |-> $past(cmd.op) == OP_SETH)
        else $error("stack top changed outside a height update");

endmodule

// ----- src/lzo_ctrl.sv -----
// Request sequencer of the layer z-order controller.
module lzo_ctrl
    import lzo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    output logic        in_take,
    output lzo_cmd_t    cmd,
    input  lzo_stat_t   stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_SETH  = 4'd3;
    localparam logic [3:0] S_SHIFT = 4'd4;
    localparam logic [3:0] S_PLACE = 4'd5;
    localparam logic [3:0] S_EMIT  = 4'd6;
    localparam logic [3:0] S_WAIT  = 4'd7;

    logic [3:0] state_reg, state_next;
    logic [2:0] rq_reg;
    logic [1:0] seq_reg, seq_next;    // index of the result being sent
    logic [1:0] cnt_reg, cnt_next;    // results in this request minus one
    logic [1:0] mode_reg, mode_next;  // 0 ack, 1 height change, 2 move, 3 refresh
    logic [1:0] ack_st_reg, ack_st_next;
    logic       dn_reg, dn_next;      // shift direction: copy from below

    assign in_ready = (state_reg == S_IDLE);
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rq_reg     <= REQ_ALLOC;
            seq_reg    <= '0;
            cnt_reg    <= '0;
            mode_reg   <= '0;
            ack_st_reg <= ST_OK;
            dn_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seq_reg    <= seq_next;
            cnt_reg    <= cnt_next;
            mode_reg   <= mode_next;
            ack_st_reg <= ack_st_next;
            dn_reg     <= dn_next;
            if (in_take)
                rq_reg <= req_type;
        end
    end

    // Next state and command decoding
    always_comb
    begin
        state_next  = state_reg;
        seq_next    = seq_reg;
        cnt_next    = cnt_reg;
        mode_next   = mode_reg;
        ack_st_next = ack_st_reg;
        dn_next     = dn_reg;
        cmd         = '0;
        cmd.op      = OP_NONE;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_LOAD;
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                seq_next    = '0;
                cnt_next    = '0;
                mode_next   = 2'd0;
                ack_st_next = ST_OK;
                state_next  = S_EMIT;
                if (rq_reg == REQ_ALLOC)
                begin
                    cmd.op      = OP_ALLOC;
                    ack_st_next = stat.free_found ? ST_OK : ST_NO_FREE;
                end
                else if (stat.req_bad)
                begin
                end
                else if (rq_reg == REQ_SIZE)
                    cmd.op = OP_SIZE;
                else if (rq_reg == REQ_MOVE)
                begin
                    cmd.op = OP_MOVE;
                    if (!stat.hidden)
                    begin
                        mode_next = 2'd2;
                        cnt_next  = 2'd3;
                    end
                end
                else if (rq_reg == REQ_REFRESH)
                begin
                    if (stat.hidden)
                        ack_st_next = ST_HIDDEN;
                    else
                        mode_next = 2'd3;
                end
                else if (rq_reg == REQ_FREE && stat.hidden)
                    cmd.op = OP_FREE;
                else if (stat.new_h != stat.old_h)
                begin
                    mode_next  = 2'd1;
                    cnt_next   = 2'd1;
                    state_next = S_SETH;
                end
            end
            S_SETH:
            begin
                cmd.op     = OP_SETH;
                // Lowering or inserting copies from below, raising or removing from above
                if (stat.old_h > stat.new_h)
                    dn_next = stat.new_h >= 0;
                else
                    dn_next = stat.old_h < 0;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                // k runs from its start towards the target, one entry a cycle
                if (dn_reg)
                begin
                    if (stat.k > stat.new_h && stat.k > 0)
                        cmd.op = OP_SHIFT_DN;
                    else
                        state_next = S_PLACE;
                end
                else
                begin
                    if ((stat.new_h >= 0 && stat.k < stat.new_h) ||
                        (stat.new_h < 0 && stat.k <= stat.top))
                        cmd.op = OP_SHIFT_UP;
                    else
                        state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (stat.new_h >= 0)
                    cmd.op = OP_PLACE;
                if (rq_reg == REQ_FREE)
                    state_next = S_WAIT;
                else
                    state_next = S_EMIT;
            end
            S_WAIT:
            begin
                cmd.op     = OP_FREE;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    cmd.status = ack_st_reg;
                    cmd.last   = (seq_reg == cnt_reg);
                    case (mode_reg)
                        2'd1:
                        begin
                            cmd.kind = (seq_reg == 2'd0) ? KIND_REBUILD : KIND_REDRAW;
                            if (stat.old_h > stat.new_h && stat.new_h >= 0)
                                cmd.hsel = 2'd1;
                            else if (stat.old_h > stat.new_h)
                                cmd.hsel = 2'd3;
                            else
                                cmd.hsel = 2'd2;
                        end
                        2'd2:
                        begin
                            cmd.kind     = seq_reg[1] ? KIND_REDRAW : KIND_REBUILD;
                            cmd.rect_sel = seq_reg[0] ? 2'd1 : 2'd0;
                            cmd.hsel     = seq_reg[0] ? 2'd2 : 2'd3;
                        end
                        2'd3:
                        begin
                            cmd.kind     = KIND_REDRAW;
                            cmd.rect_sel = 2'd2;
                            cmd.hsel     = 2'd2;
                        end
                        default:
                            cmd.kind = KIND_ACK;
                    endcase
                    if (seq_reg == cnt_reg)
                        state_next = S_IDLE;
                    else
                        seq_next = seq_reg + 2'd1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Input is only taken with the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == S_LOAD)
        else $error("accepted item not loaded");
    // The last result returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT && cmd.last) |=> state_reg == S_IDLE)
        else $error("sequencer did not finish after last result");
    // Shifting never runs past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> stat.k <= 7'(MAX_LAYERS))
        else $error("shift position out of range");

endmodule

// ----- src/layer_z_order_controller_top.sv -----
// Top level of the layer z-order controller.
//
// The block keeps a table of up to 32 display layers and their z-order stack.
// Requests arrive on the in_valid/in_ready channel, one item at a time; each
// request yields one to four result items on out_valid/out_ready, the final
// one marked by last. Screen size registers are written on the cfg channel
// (index 0 width, index 1 height); the user must write them only while the
// block is idle, which the block itself does not enforce. cfg_ready is
// always high. An item is loaded and then decoded; a height change then
// walks the stack one entry per cycle, and each result is then placed in
// the output register.
// A new item is accepted only once every result of the previous one has been
// placed in the output register. When the receiver stalls, the result is
// held in that register and the sequencer waits.
// Reset clears the in-use flags, empties the stack and restores the screen
// size to 320 by 200. Other table contents are undefined until written.
module layer_z_order_controller_top
    import lzo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [4:0]         layer_id,
    input  logic signed [14:0] pos_x,
    input  logic signed [14:0] pos_y,
    input  logic signed [14:0] end_x,
    input  logic signed [14:0] end_y,
    input  logic signed [15:0] new_height,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [12:0]        rect_x0,
    output logic [12:0]        rect_y0,
    output logic [12:0]        rect_x1,
    output logic [12:0]        rect_y1,
    output logic signed [6:0]  height_from,
    output logic signed [6:0]  height_to,
    output logic [4:0]         result_layer,
    output logic [1:0]         status,
    output logic               last
);

    lzo_cmd_t  cmd;
    lzo_stat_t stat;
    logic      in_take;

    assign cfg_ready = 1'b1;

    // Sequencer
    lzo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .in_take  (in_take),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Table, stack and result datapath
    lzo_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_take      (in_take),
        .req_type     (req_type),
        .layer_id     (layer_id),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .new_height   (new_height),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .rect_x0      (rect_x0),
        .rect_y0      (rect_y0),
        .rect_x1      (rect_x1),
        .rect_y1      (rect_y1),
        .height_from  (height_from),
        .height_to    (height_to),
        .result_layer (result_layer),
        .status       (status),
        .last         (last)
    );

endmodule
